// File: rtl/dmm_pkg.sv
// shared types, codes and constants for the dense matrix multiply block
package dmm_pkg;

    localparam int MAX_DIM_DEFAULT       = 32;
    localparam int ELEMENT_WIDTH_DEFAULT = 16;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 5;
    localparam int VALUE_W   = 16;
    localparam int PRODUCT_W = 37;
    localparam int DIM_W     = 6;

    localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [PRODUCT_W-1:0] product_value;
        logic [IDX_W-1:0]            out_row;
        logic [IDX_W-1:0]            out_col;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic start;
        logic issue;
        logic load_out;
    } dmm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic k_done;
        logic pipe_busy;
    } dmm_status_t;

endpackage

// File: rtl/dmm_datapath.sv
// element stores, multiply-accumulate pipeline and result register
module dmm_datapath #(
    parameter int MAX_DIM       = dmm_pkg::MAX_DIM_DEFAULT,
    parameter int ELEMENT_WIDTH = dmm_pkg::ELEMENT_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dmm_pkg::item_t                 item,
    input  logic                           cfg_valid,
    input  logic [dmm_pkg::DIM_W-1:0]      cfg_data,
    input  dmm_pkg::dmm_cmd_t              cmd,
    output dmm_pkg::dmm_status_t           status,
    output dmm_pkg::result_t               result
);
    import dmm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int KC_W   = $clog2(MAX_DIM + 1);
    localparam int PROD_W = 2 * ELEMENT_WIDTH;

    logic [ELEMENT_WIDTH-1:0] mem_a [DEPTH];
    logic [ELEMENT_WIDTH-1:0] mem_b [DEPTH];

    logic [DIM_W-1:0]     dim_reg;
    logic [KC_W-1:0]      k_reg, k_next;
    logic [KC_W-1:0]      lim_reg;
    logic [KC_W-1:0]      dim_eff;
    logic [IDX_W-1:0]     q_row_reg;
    logic [IDX_W-1:0]     q_col_reg;
    logic                 zero_a_reg;
    logic                 zero_b_reg;
    logic                 zero_a_s1_reg;
    logic                 zero_b_s1_reg;
    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic [ELEMENT_WIDTH-1:0] a_rd_reg;
    logic [ELEMENT_WIDTH-1:0] b_rd_reg;
    logic signed [ELEMENT_WIDTH-1:0] a_op;
    logic signed [ELEMENT_WIDTH-1:0] b_op;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [PRODUCT_W-1:0]     acc_reg, acc_next;
    result_t                         result_reg;

    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr_a;
    logic [ADDR_W-1:0]        rd_addr_b;
    logic                     wr_in_range;
    logic [ELEMENT_WIDTH-1:0] wr_elem;

    // load address and range check
    assign wr_addr = ADDR_W'(ADDR_W'(item.row) * ADDR_W'(MAX_DIM)) + ADDR_W'(item.col);
    assign wr_in_range = (32'(item.row) < MAX_DIM) && (32'(item.col) < MAX_DIM);
    assign wr_elem = ELEMENT_WIDTH'($unsigned(item.value));

    // walk row of A and column of B
    assign rd_addr_a = ADDR_W'(ADDR_W'(q_row_reg) * ADDR_W'(MAX_DIM)) + ADDR_W'(k_reg);
    assign rd_addr_b = ADDR_W'(ADDR_W'(k_reg) * ADDR_W'(MAX_DIM)) + ADDR_W'(q_col_reg);

    // sizes above the store dimension saturate
    assign dim_eff = (32'(dim_reg) > MAX_DIM) ? KC_W'(MAX_DIM) : KC_W'(dim_reg);

    assign k_next = k_reg + KC_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a && wr_in_range)
        begin
            mem_a[wr_addr] <= wr_elem;
        end
        a_rd_reg <= mem_a[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_b && wr_in_range)
        begin
            mem_b[wr_addr] <= wr_elem;
        end
        b_rd_reg <= mem_b[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg      <= DIM_RESET;
            k_reg        <= '0;
            lim_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                dim_reg <= cfg_data;
            end
            if (cmd.start)
            begin
                k_reg   <= '0;
                lim_reg <= dim_eff;
            end
            else if (cmd.issue)
            begin
                k_reg <= k_next;
            end
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // out-of-range row or column reads as zero
    assign a_op = zero_a_s1_reg ? '0 : $signed(a_rd_reg);
    assign b_op = zero_b_s1_reg ? '0 : $signed(b_rd_reg);

    assign acc_next = acc_reg + PRODUCT_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            q_row_reg  <= item.row;
            q_col_reg  <= item.col;
            zero_a_reg <= !(32'(item.row) < MAX_DIM);
            zero_b_reg <= !(32'(item.col) < MAX_DIM);
        end
        zero_a_s1_reg <= zero_a_reg;
        zero_b_s1_reg <= zero_b_reg;
        prod_reg      <= a_op * b_op;
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.load_out)
        begin
            result_reg.product_value <= acc_reg;
            result_reg.out_row       <= q_row_reg;
            result_reg.out_col       <= q_col_reg;
        end
    end

    assign status.k_done    = (k_reg == lim_reg);
    assign status.pipe_busy = s1_valid_reg | s2_valid_reg;
    assign result           = result_reg;

endmodule

// File: rtl/dmm_controller.sv
// sequencing state machine and handshake control
module dmm_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic [dmm_pkg::OP_W-1:0]    operation,
    output logic                        result_valid,
    input  logic                        result_ready,
    input  dmm_pkg::dmm_status_t        status,
    output dmm_pkg::dmm_cmd_t           cmd
);
    import dmm_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       slot_free;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign slot_free  = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.wr_a     = accept && (operation == OP_LOAD_A);
        cmd.wr_b     = accept && (operation == OP_LOAD_B);
        cmd.start    = accept && (operation == OP_QUERY);
        cmd.issue    = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.k_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last product to land and the result slot to clear
                if (!status.pipe_busy && slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out || (out_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

// File: rtl/dense_matrix_multiply.sv
// Dense square matrix multiply. Load items write one element of A or B into
// on-chip stores. A query computes one element of C = A x B by walking the A
// row and B column with one multiply-accumulate per cycle, over the configured
// size capped at MAX_DIM; the single read port of each store sets that rate.
// A finished result waits in an output register, so the next item is taken
// while it is still pending. The size register is written through the cfg
// channel, which is always ready and must only be used while idle.
// Store entries read before they were ever loaded give undefined results.
module dense_matrix_multiply #(
    parameter int MAX_DIM       = dmm_pkg::MAX_DIM_DEFAULT,
    parameter int ELEMENT_WIDTH = dmm_pkg::ELEMENT_WIDTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  dmm_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_ready,
    output dmm_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [dmm_pkg::DIM_W-1:0]  cfg_data
);
    import dmm_pkg::*;

    dmm_cmd_t    cmd;
    dmm_status_t status;

    assign cfg_ready = 1'b1;

    dmm_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (item.operation),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    dmm_datapath #(
        .MAX_DIM       (MAX_DIM),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

// File: test/dense_matrix_multiply_tb.sv
// testbench for the dense matrix multiply block: element loads, product queries and size register
module dense_matrix_multiply_tb;
    import dmm_pkg::*;

    localparam int MAX_DIM      = MAX_DIM_DEFAULT;
    localparam int DRAIN_CYCLES = MAX_DIM + 16;
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_HOLD    = 400;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    item_t            item;
    logic             result_valid;
    logic             result_ready;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [DIM_W-1:0] cfg_data;

    dense_matrix_multiply u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // shadow copy of both matrices and of the size register
    logic signed [VALUE_W-1:0] a_elem [MAX_DIM][MAX_DIM];
    logic signed [VALUE_W-1:0] b_elem [MAX_DIM][MAX_DIM];
    bit                        a_loaded [MAX_DIM][MAX_DIM];
    bit                        b_loaded [MAX_DIM][MAX_DIM];
    logic [DIM_W-1:0]          dim_setting;

    result_t pending_products [$];
    result_t oldest_product;
    int      error_count    = 0;
    int      accepted_items = 0;
    bit      idle_on        = 1'b1;
    int      hold_cycles    = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int summed_span();
        return (dim_setting > MAX_DIM) ? MAX_DIM : int'(dim_setting);
    endfunction

    function automatic result_t product_of(input item_t it);
        longint  acc;
        result_t r;
        acc = 0;
        for (int k = 0; k < summed_span(); k++)
        begin
            acc += longint'(a_elem[it.row][k]) * longint'(b_elem[k][it.col]);
        end
        r.product_value = acc[PRODUCT_W-1:0];
        r.out_row       = it.row;
        r.out_col       = it.col;
        return r;
    endfunction

    // true when every element the query would read has been loaded
    function automatic bit operands_loaded(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
        for (int k = 0; k < summed_span(); k++)
        begin
            if (!a_loaded[r][k] || !b_loaded[k][c])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 15))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return DIM_W'($urandom_range(1, 4));
        else if (p < 75)
            return DIM_W'($urandom_range(5, 12));
        else if (p < 88)
            return DIM_W'($urandom_range(13, 31));
        else if (p < 93)
            return DIM_W'(MAX_DIM);
        else if (p < 97)
            return DIM_W'($urandom_range(33, 63));
        else
            return '0;
    endfunction

    function automatic void note_accepted(input item_t it);
        case (it.operation)
            OP_LOAD_A:
            begin
                a_elem[it.row][it.col]   = it.value;
                a_loaded[it.row][it.col] = 1'b1;
            end
            OP_LOAD_B:
            begin
                b_elem[it.row][it.col]   = it.value;
                b_loaded[it.row][it.col] = 1'b1;
            end
            OP_QUERY:
                pending_products.push_back(product_of(it));
            default:
                ;
        endcase
        if (it.operation != OP_UNUSED)
            accepted_items++;
    endfunction

    // valid stays high across back-to-back transfers, this task drops it only for a gap
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic signed [VALUE_W-1:0] v);
        item_t it;
        int    gap;
        it.operation = op;
        it.row       = r;
        it.col       = c;
        it.value     = v;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (!item_ready);
        note_accepted(it);
    endtask

    // size changes only once the block has drained
    task automatic write_dim(input logic [DIM_W-1:0] d);
        item_valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        dim_setting = d;
    endtask

    task automatic prepare_operands(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                    input int refresh_pct);
        for (int k = 0; k < summed_span(); k++)
        begin
            if (!a_loaded[r][k] || $urandom_range(0, 99) < refresh_pct)
                send_item(OP_LOAD_A, r, IDX_W'(k), rand_value());
        end
        for (int k = 0; k < summed_span(); k++)
        begin
            if (!b_loaded[k][c] || $urandom_range(0, 99) < refresh_pct)
                send_item(OP_LOAD_B, IDX_W'(k), c, rand_value());
        end
    endtask

    // full-size sums at both ends of the product range, using the reset size
    task automatic test_extreme_sums();
        for (int k = 0; k < MAX_DIM; k++)
        begin
            send_item(OP_LOAD_A, 5'd31, IDX_W'(k), 16'sh8000);
            send_item(OP_LOAD_B, IDX_W'(k), 5'd0, 16'sh8000);
            send_item(OP_LOAD_B, IDX_W'(k), 5'd31, 16'sh7fff);
        end
        send_item(OP_QUERY, 5'd31, 5'd0, 16'sh0000);
        send_item(OP_QUERY, 5'd31, 5'd31, 16'shffff);
    endtask

    // sizes above the store dimension saturate
    task automatic test_oversize_size();
        write_dim(6'd63);
        send_item(OP_QUERY, 5'd31, 5'd0, rand_value());
        write_dim(6'd33);
        send_item(OP_QUERY, 5'd31, 5'd31, rand_value());
        write_dim(DIM_W'(MAX_DIM));
        send_item(OP_QUERY, 5'd31, 5'd0, rand_value());
    endtask

    // empty sum, nothing is read
    task automatic test_size_zero();
        write_dim('0);
        send_item(OP_QUERY, 5'd0, 5'd0, rand_value());
        send_item(OP_QUERY, 5'd17, 5'd9, rand_value());
    endtask

    task automatic test_unused_op();
        write_dim(6'd1);
        send_item(OP_UNUSED, 5'd31, 5'd0, 16'sh0005);
        send_item(OP_UNUSED, 5'd0, 5'd0, 16'sh7fff);
        send_item(OP_QUERY, 5'd31, 5'd0, rand_value());
        send_item(OP_UNUSED, 5'd31, 5'd31, 16'sh8000);
        send_item(OP_QUERY, 5'd31, 5'd31, rand_value());
    endtask

    // short sums, a row past the size in use, and an overwrite
    task automatic test_small_products();
        write_dim(6'd2);
        send_item(OP_LOAD_A, 5'd0, 5'd0, 16'sh0003);
        send_item(OP_LOAD_A, 5'd0, 5'd1, -16'sh0004);
        send_item(OP_LOAD_B, 5'd0, 5'd1, 16'sh0005);
        send_item(OP_LOAD_B, 5'd1, 5'd1, 16'sh0007);
        send_item(OP_QUERY, 5'd0, 5'd1, rand_value());
        send_item(OP_QUERY, 5'd31, 5'd0, rand_value());
        send_item(OP_LOAD_A, 5'd0, 5'd0, 16'sh7fff);
        send_item(OP_QUERY, 5'd0, 5'd1, rand_value());
    endtask

    // receiver holds off while queries keep coming, so the input stalls
    task automatic test_output_stall();
        write_dim(6'd4);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
                prepare_operands(IDX_W'(r), IDX_W'(c), 0);
        end
        hold_cycles = LONG_HOLD;
        repeat (16)
            send_item(OP_QUERY, IDX_W'($urandom_range(0, 2)), IDX_W'($urandom_range(0, 2)),
                      rand_value());
    endtask

    task automatic test_random_mix(input int target);
        int               start_count;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        start_count = accepted_items;
        while (accepted_items - start_count < target)
        begin
            write_dim(pick_dim());
            repeat ($urandom_range(3, 10))
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    r = IDX_W'($urandom);
                    c = IDX_W'($urandom);
                    prepare_operands(r, c, 15);
                    send_item(OP_QUERY, r, c, rand_value());
                    // reuse whatever rows and columns are already loaded
                    repeat (3)
                    begin
                        r = IDX_W'($urandom);
                        c = IDX_W'($urandom);
                        if (operands_loaded(r, c))
                            send_item(OP_QUERY, r, c, rand_value());
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        op = OP_W'($urandom_range(0, 3));
                        r  = IDX_W'($urandom);
                        c  = IDX_W'($urandom);
                        if (op == OP_QUERY && !operands_loaded(r, c))
                            op = $urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A;
                        send_item(op, r, c, rand_value());
                    end
                end
            end
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        test_random_mix(80);
    endtask

    // receiver: random stalls plus the one long hold-off
    initial
    begin
        int hold_left;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_left   = hold_cycles;
                hold_cycles = 0;
                result_ready <= 1'b0;
                repeat (hold_left) @(posedge clk);
                result_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // each result transfer is matched against the oldest expected product
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_products.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: product %0d at (%0d,%0d)",
                             result.product_value, result.out_row, result.out_col);
            end
            else
            begin
                oldest_product = pending_products.pop_front();
                if (result.product_value !== oldest_product.product_value ||
                    result.out_row !== oldest_product.out_row ||
                    result.out_col !== oldest_product.out_col)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: expected %0d at (%0d,%0d), got %0d at (%0d,%0d)",
                                 oldest_product.product_value, oldest_product.out_row,
                                 oldest_product.out_col, result.product_value,
                                 result.out_row, result.out_col);
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        item        <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        dim_setting = DIM_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_extreme_sums();
        test_oversize_size();
        test_size_zero();
        test_unused_op();
        test_small_products();
        test_output_stall();
        test_random_mix(520);
        test_steady_stream();

        item_valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_products.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
